// File: rtl/spa_pkg.sv
// shared constants, codes and control types of the sparse polynomial adder
`timescale 1ns / 1ps

package spa_pkg;

  localparam int unsigned MaxTerms = 16;
  localparam int unsigned IdxW     = $clog2(MaxTerms);
  localparam int unsigned CntW     = $clog2(MaxTerms + 1);

  localparam int unsigned CmdW   = 2;
  localparam int unsigned PowW   = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned SumW   = CoefW + 1;
  localparam int unsigned TermW  = PowW + CoefW;
  localparam int unsigned StatW  = 3;

  // command codes
  localparam logic [CmdW-1:0] CmdLoadFirst  = 2'd0;
  localparam logic [CmdW-1:0] CmdLoadSecond = 2'd1;
  localparam logic [CmdW-1:0] CmdAdd        = 2'd2;
  localparam logic [CmdW-1:0] CmdUnused     = 2'd3;

  // status codes
  localparam logic [StatW-1:0] StSum         = 3'd0;
  localparam logic [StatW-1:0] StAccepted    = 3'd1;
  localparam logic [StatW-1:0] StOrder       = 3'd2;
  localparam logic [StatW-1:0] StFull        = 3'd3;
  localparam logic [StatW-1:0] StFirstEmpty  = 3'd4;
  localparam logic [StatW-1:0] StSecondEmpty = 3'd5;

  typedef enum logic [2:0] {
    OpNone,
    OpLoadFirst,
    OpLoadSecond,
    OpErrFirst,
    OpErrSecond,
    OpMergeStart,
    OpMergeStep
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic first_empty;
    logic second_empty;
    logic merge_last;
  } dp_stat_t;

endpackage

// File: rtl/sparse_polynomial_adder.sv
// top level of the sparse polynomial adder: controller plus datapath
`timescale 1ns / 1ps

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+------------------------------
// command   | command_i, term_power_i, term_coefficient_i   | beat taken when start & !busy
// result    | out_power_o, out_coefficient_o, status_o,     | beat shown for one cycle
//           | last_result_o                                 | while strobe_o is high
//
// a load beat gives one status beat on the cycle after it is taken; loads can be
// taken every cycle since busy stays low for them
// an add beat reads both term rams one entry per cycle and emits one merged
// term per cycle, up to na + nb merged terms in all
// busy is high from the cycle after an add with both lists nonempty is taken until its last term is computed
// an error status for an empty list is a single beat, like a load
// reset clears both list counts; the term rams are not cleared
// the receiver cannot stall: every result beat is presented exactly once

module sparse_polynomial_adder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [spa_pkg::CmdW-1:0]         command_i,
  input  logic [spa_pkg::PowW-1:0]         term_power_i,
  input  logic signed [spa_pkg::CoefW-1:0] term_coefficient_i,
  output logic                             strobe_o,
  output logic [spa_pkg::PowW-1:0]         out_power_o,
  output logic signed [spa_pkg::SumW-1:0]  out_coefficient_o,
  output logic [spa_pkg::StatW-1:0]        status_o,
  output logic                             last_result_o
);

  // controller drives one datapath operation per cycle
  spa_pkg::dp_cmd_t  dp_cmd;
  // datapath reports empty lists and the final merge step
  spa_pkg::dp_stat_t dp_stat;

  spa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy      (busy)
  );

  // holds both term lists in rams, the merge indices and the result registers
  spa_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .term_power_i       (term_power_i),
    .term_coefficient_i (term_coefficient_i),
    .stat_o             (dp_stat),
    .out_power_o        (out_power_o),
    .out_coefficient_o  (out_coefficient_o),
    .status_o           (status_o),
    .last_result_o      (last_result_o),
    .strobe_o           (strobe_o)
  );

endmodule

// File: rtl/spa_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module spa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spa_datapath.sv
// term stores, list counters, merge indices and result registers
`timescale 1ns / 1ps

module spa_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spa_pkg::dp_cmd_t               cmd_i,
  input  logic [spa_pkg::PowW-1:0]       term_power_i,
  input  logic signed [spa_pkg::CoefW-1:0] term_coefficient_i,
  output spa_pkg::dp_stat_t              stat_o,
  output logic [spa_pkg::PowW-1:0]       out_power_o,
  output logic signed [spa_pkg::SumW-1:0] out_coefficient_o,
  output logic [spa_pkg::StatW-1:0]      status_o,
  output logic                           last_result_o,
  output logic                           strobe_o
);

  logic [spa_pkg::CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [spa_pkg::PowW-1:0] lastp_a_q, lastp_a_d, lastp_b_q, lastp_b_d;
  logic [spa_pkg::CntW-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;

  logic [spa_pkg::PowW-1:0]         pow_q, pow_d;
  logic signed [spa_pkg::SumW-1:0]  coef_q, coef_d;
  logic [spa_pkg::StatW-1:0]        stat_q, stat_d;
  logic                             last_q, last_d;
  logic                             valid_q, valid_d;

  logic                     load_b, we_a, we_b, full, order_bad;
  logic [spa_pkg::CntW-1:0] ld_cnt;
  logic [spa_pkg::PowW-1:0] ld_lastp;
  logic [spa_pkg::StatW-1:0] ld_stat;
  logic [spa_pkg::TermW-1:0] wdata, rd_a, rd_b;

  logic [spa_pkg::PowW-1:0]         a_pow, b_pow;
  logic signed [spa_pkg::CoefW-1:0] a_coef, b_coef;
  logic                             a_ok, b_ok, eq, take_a, adv_a, adv_b;
  logic [spa_pkg::CntW-1:0]         nxt_a, nxt_b;

  assign wdata = {term_power_i, term_coefficient_i};

  spa_ram #(.Width(spa_pkg::TermW), .Depth(spa_pkg::MaxTerms)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[spa_pkg::IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_a_d[spa_pkg::IdxW-1:0]),
    .rdata_o (rd_a)
  );

  spa_ram #(.Width(spa_pkg::TermW), .Depth(spa_pkg::MaxTerms)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[spa_pkg::IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_b_d[spa_pkg::IdxW-1:0]),
    .rdata_o (rd_b)
  );

  // load checks: full first, then strictly falling power
  assign load_b    = (cmd_i.op == spa_pkg::OpLoadSecond);
  assign ld_cnt    = load_b ? cnt_b_q : cnt_a_q;
  assign ld_lastp  = load_b ? lastp_b_q : lastp_a_q;
  assign full      = (ld_cnt == spa_pkg::CntW'(spa_pkg::MaxTerms));
  assign order_bad = (ld_cnt != '0) && (term_power_i >= ld_lastp);
  assign ld_stat   = full ? spa_pkg::StFull :
                     (order_bad ? spa_pkg::StOrder : spa_pkg::StAccepted);
  assign we_a = (cmd_i.op == spa_pkg::OpLoadFirst) && !full && !order_bad;
  assign we_b = load_b && !full && !order_bad;

  // merge heads come from the registered ram reads at the current indices
  assign a_pow  = rd_a[spa_pkg::TermW-1 -: spa_pkg::PowW];
  assign a_coef = rd_a[spa_pkg::CoefW-1:0];
  assign b_pow  = rd_b[spa_pkg::TermW-1 -: spa_pkg::PowW];
  assign b_coef = rd_b[spa_pkg::CoefW-1:0];
  assign a_ok   = (idx_a_q < cnt_a_q);
  assign b_ok   = (idx_b_q < cnt_b_q);
  assign eq     = a_ok && b_ok && (a_pow == b_pow);
  assign take_a = !b_ok || (a_ok && (a_pow > b_pow));
  assign adv_a  = eq || take_a;
  assign adv_b  = eq || !take_a;
  assign nxt_a  = adv_a ? idx_a_q + spa_pkg::CntW'(1) : idx_a_q;
  assign nxt_b  = adv_b ? idx_b_q + spa_pkg::CntW'(1) : idx_b_q;

  assign stat_o.first_empty  = (cnt_a_q == '0);
  assign stat_o.second_empty = (cnt_b_q == '0);
  assign stat_o.merge_last   = (nxt_a == cnt_a_q) && (nxt_b == cnt_b_q);

  always_comb begin
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    lastp_a_d = lastp_a_q;
    lastp_b_d = lastp_b_q;
    idx_a_d   = idx_a_q;
    idx_b_d   = idx_b_q;
    pow_d     = '0;
    coef_d    = '0;
    stat_d    = spa_pkg::StSum;
    last_d    = 1'b1;
    valid_d   = 1'b0;
    if (we_a) begin
      cnt_a_d   = cnt_a_q + spa_pkg::CntW'(1);
      lastp_a_d = term_power_i;
    end
    if (we_b) begin
      cnt_b_d   = cnt_b_q + spa_pkg::CntW'(1);
      lastp_b_d = term_power_i;
    end
    case (cmd_i.op)
      spa_pkg::OpLoadFirst, spa_pkg::OpLoadSecond: begin
        stat_d  = ld_stat;
        valid_d = 1'b1;
      end
      spa_pkg::OpErrFirst: begin
        stat_d  = spa_pkg::StFirstEmpty;
        valid_d = 1'b1;
      end
      spa_pkg::OpErrSecond: begin
        stat_d  = spa_pkg::StSecondEmpty;
        valid_d = 1'b1;
      end
      spa_pkg::OpMergeStart: begin
        idx_a_d = '0;
        idx_b_d = '0;
      end
      spa_pkg::OpMergeStep: begin
        idx_a_d = nxt_a;
        idx_b_d = nxt_b;
        valid_d = 1'b1;
        last_d  = stat_o.merge_last;
        if (eq) begin
          pow_d  = a_pow;
          coef_d = spa_pkg::SumW'(a_coef) + spa_pkg::SumW'(b_coef);
        end else if (take_a) begin
          pow_d  = a_pow;
          coef_d = spa_pkg::SumW'(a_coef);
        end else begin
          pow_d  = b_pow;
          coef_d = spa_pkg::SumW'(b_coef);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      lastp_a_q <= '0;
      lastp_b_q <= '0;
      idx_a_q   <= '0;
      idx_b_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      lastp_a_q <= lastp_a_d;
      lastp_b_q <= lastp_b_d;
      idx_a_q   <= idx_a_d;
      idx_b_q   <= idx_b_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pow_q  <= pow_d;
    coef_q <= coef_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign out_power_o       = pow_q;
  assign out_coefficient_o = coef_q;
  assign status_o          = stat_q;
  assign last_result_o     = last_q;
  assign strobe_o          = valid_q;

endmodule

// File: rtl/spa_ctrl.sv
// command decode and merge sequencing state machine
`timescale 1ns / 1ps

module spa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [spa_pkg::CmdW-1:0]  command_i,
  input  spa_pkg::dp_stat_t         stat_i,
  output spa_pkg::dp_cmd_t          cmd_o,
  output logic                      busy
);

  typedef enum logic {
    StIdle,
    StMerge
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        busy_q, busy_d;
  logic        accept;

  assign accept = start && !busy_q;

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    cmd_o.op   = spa_pkg::OpNone;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (command_i)
            spa_pkg::CmdLoadFirst:  cmd_o.op = spa_pkg::OpLoadFirst;
            spa_pkg::CmdLoadSecond: cmd_o.op = spa_pkg::OpLoadSecond;
            spa_pkg::CmdAdd: begin
              if (stat_i.first_empty) begin
                cmd_o.op = spa_pkg::OpErrFirst;
              end else if (stat_i.second_empty) begin
                cmd_o.op = spa_pkg::OpErrSecond;
              end else begin
                cmd_o.op = spa_pkg::OpMergeStart;
                state_d  = StMerge;
                busy_d   = 1'b1;
              end
            end
            default: cmd_o.op = spa_pkg::OpNone;
          endcase
        end
      end
      StMerge: begin
        cmd_o.op = spa_pkg::OpMergeStep;
        if (stat_i.merge_last) begin
          state_d = StIdle;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

// File: rtl/spa_checker.sv
// port-level assertions for the sparse polynomial adder, bound to the top level
`timescale 1ns / 1ps

module spa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic [spa_pkg::CmdW-1:0]         command_i,
  input logic                             strobe_o,
  input logic [spa_pkg::StatW-1:0]        status_o,
  input logic                             last_result_o
);

  // a status beat is always the only and final beat of its command
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != spa_pkg::StSum) |-> last_result_o)
    else $error("status beat without last_result");

  // a load answers on the next cycle with a load status
  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy &&
    (command_i == spa_pkg::CmdLoadFirst || command_i == spa_pkg::CmdLoadSecond)
    |=> strobe_o && (status_o == spa_pkg::StAccepted ||
                     status_o == spa_pkg::StOrder || status_o == spa_pkg::StFull))
    else $error("load did not answer with a load status");

  // a sum term that is not last is followed at once by another sum term
  a_sum_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == spa_pkg::StSum) && !last_result_o
    |=> strobe_o && (status_o == spa_pkg::StSum))
    else $error("merge run broken");

  // no new command can be taken in the middle of a merge run
  a_sum_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == spa_pkg::StSum) && !last_result_o |-> busy)
    else $error("not busy during merge run");

  // the unused command gives no beat
  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i == spa_pkg::CmdUnused) |=> !strobe_o)
    else $error("unused command produced a beat");

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .strobe_o      (strobe_o),
  .status_o      (status_o),
  .last_result_o (last_result_o)
);

// File: bench/tb.sv
// testbench of the sparse polynomial adder: load and merge beats checked against a model
`timescale 1ns / 1ps

module tb;

  // run limits
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandBeats   = 400;

  // one result beat as the block shows it
  typedef struct {
    logic [spa_pkg::PowW-1:0]         pw;
    logic signed [spa_pkg::SumW-1:0]  cf;
    logic [spa_pkg::StatW-1:0]        st;
    logic                             is_last;
  } result_beat_t;

  // shadow copy of both term lists plus the result beats still owed by the block
  class poly_sum_model;
    logic [spa_pkg::PowW-1:0]         term_pow [2][spa_pkg::MaxTerms];
    logic signed [spa_pkg::CoefW-1:0] term_coef [2][spa_pkg::MaxTerms];
    int unsigned                      term_cnt [2];
    result_beat_t                     beats_due [$];
    int unsigned                      mismatches;

    function new();
      term_cnt[0] = 0;
      term_cnt[1] = 0;
      mismatches  = 0;
    endfunction

    function void push_beat(logic [spa_pkg::PowW-1:0] pw,
                            logic signed [spa_pkg::SumW-1:0] cf,
                            logic [spa_pkg::StatW-1:0] st, logic is_last);
      result_beat_t b;
      b.pw      = pw;
      b.cf      = cf;
      b.st      = st;
      b.is_last = is_last;
      beats_due.push_back(b);
    endfunction

    // full is checked before order; a rejected term leaves the list alone
    function logic [spa_pkg::StatW-1:0] store_term(int unsigned l,
                                                   logic [spa_pkg::PowW-1:0] pw,
                                                   logic signed [spa_pkg::CoefW-1:0] cf);
      int unsigned n;
      n = term_cnt[l];
      if (n >= spa_pkg::MaxTerms) return spa_pkg::StFull;
      if (n > 0 && pw >= term_pow[l][n-1]) return spa_pkg::StOrder;
      term_pow[l][n]  = pw;
      term_coef[l][n] = cf;
      term_cnt[l]     = n + 1;
      return spa_pkg::StAccepted;
    endfunction

    // merge by falling power, equal powers summed, zero sums kept
    function void merge_lists();
      int unsigned                     i;
      int unsigned                     j;
      int unsigned                     na;
      int unsigned                     nb;
      logic [spa_pkg::PowW-1:0]        p;
      logic signed [spa_pkg::SumW-1:0] c;
      na = term_cnt[0];
      nb = term_cnt[1];
      i  = 0;
      j  = 0;
      while (i < na || j < nb) begin
        if (i < na && j < nb && term_pow[0][i] == term_pow[1][j]) begin
          p = term_pow[0][i];
          c = term_coef[0][i];
          c = c + term_coef[1][j];
          i++;
          j++;
        end else if (j >= nb || (i < na && term_pow[0][i] > term_pow[1][j])) begin
          p = term_pow[0][i];
          c = term_coef[0][i];
          i++;
        end else begin
          p = term_pow[1][j];
          c = term_coef[1][j];
          j++;
        end
        push_beat(p, c, spa_pkg::StSum, (i >= na && j >= nb));
      end
    endfunction

    function void take_command(logic [spa_pkg::CmdW-1:0] cmd,
                               logic [spa_pkg::PowW-1:0] pw,
                               logic signed [spa_pkg::CoefW-1:0] cf);
      case (cmd)
        spa_pkg::CmdLoadFirst: begin
          push_beat('0, '0, store_term(0, pw, cf), 1'b1);
        end
        spa_pkg::CmdLoadSecond: begin
          push_beat('0, '0, store_term(1, pw, cf), 1'b1);
        end
        spa_pkg::CmdAdd: begin
          if (term_cnt[0] == 0) push_beat('0, '0, spa_pkg::StFirstEmpty, 1'b1);
          else if (term_cnt[1] == 0) push_beat('0, '0, spa_pkg::StSecondEmpty, 1'b1);
          else merge_lists();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(logic [spa_pkg::PowW-1:0] pw,
                             logic signed [spa_pkg::SumW-1:0] cf,
                             logic [spa_pkg::StatW-1:0] st, logic is_last);
      result_beat_t e;
      if (beats_due.size() == 0) begin
        $error("unexpected result beat: power %0d coefficient %0d status %0d last %0b",
               pw, cf, st, is_last);
        mismatches++;
        return;
      end
      e = beats_due.pop_front();
      if (pw !== e.pw) begin
        $error("out_power: expected %0d, actual %0d", e.pw, pw);
        mismatches++;
      end
      if (cf !== e.cf) begin
        $error("out_coefficient: expected %0d, actual %0d", e.cf, cf);
        mismatches++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        mismatches++;
      end
      if (is_last !== e.is_last) begin
        $error("last_result: expected %0b, actual %0b", e.is_last, is_last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic [spa_pkg::CmdW-1:0]         command_i;
  logic [spa_pkg::PowW-1:0]         term_power_i;
  logic signed [spa_pkg::CoefW-1:0] term_coefficient_i;
  logic                             strobe_o;
  logic [spa_pkg::PowW-1:0]         out_power_o;
  logic signed [spa_pkg::SumW-1:0]  out_coefficient_o;
  logic [spa_pkg::StatW-1:0]        status_o;
  logic                             last_result_o;

  poly_sum_model model = new();
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;

  sparse_polynomial_adder u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .term_power_i       (term_power_i),
    .term_coefficient_i (term_coefficient_i),
    .strobe_o           (strobe_o),
    .out_power_o        (out_power_o),
    .out_coefficient_o  (out_coefficient_o),
    .status_o           (status_o),
    .last_result_o      (last_result_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result beats checked first, then the command beat taken at this edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o !== 1'b0) begin
        model.check_beat(out_power_o, out_coefficient_o, status_o, last_result_o);
      end
      if (start && !busy) begin
        model.take_command(command_i, term_power_i, term_coefficient_i);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one command beat and hold it until taken; returns at the next falling edge
  task automatic send_beat(input logic [spa_pkg::CmdW-1:0] cmd,
                           input logic [spa_pkg::PowW-1:0] pw,
                           input logic signed [spa_pkg::CoefW-1:0] cf);
    start              = 1'b1;
    command_i          = cmd;
    term_power_i       = pw;
    term_coefficient_i = cf;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // mostly back to back, some short gaps, a few long ones, and bursts with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(15, 30);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive_gapped(input logic [spa_pkg::CmdW-1:0] cmd,
                              input logic [spa_pkg::PowW-1:0] pw,
                              input logic signed [spa_pkg::CoefW-1:0] cf);
    int unsigned gap;
    send_beat(cmd, pw, cf);
    gap = pick_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // sender holds off until every owed result beat has come
  task automatic wait_drained();
    if (model.pending() != 0) begin
      start = 1'b0;
      while (model.pending() != 0) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [spa_pkg::CoefW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return spa_pkg::CoefW'($urandom);
    endcase
  endfunction

  // a power below the last stored nonzero one, spaced so the list can still reach full
  function automatic logic [spa_pkg::PowW-1:0] next_power(int unsigned l);
    int unsigned cnt;
    int unsigned last_pow;
    int unsigned room;
    int unsigned step;
    cnt = model.term_cnt[l];
    if (cnt == 0) return spa_pkg::PowW'($urandom_range(64, 255));
    last_pow = model.term_pow[l][cnt-1];
    room     = spa_pkg::MaxTerms - cnt;
    if (room == 1 && $urandom_range(0, 1) == 1) return '0;
    if (last_pow == 0) return spa_pkg::PowW'($urandom);
    step = last_pow / room;
    if (step < 1) step = 1;
    return spa_pkg::PowW'(last_pow - $urandom_range(1, step));
  endfunction

  initial begin
    int unsigned                      beats_sent;
    int unsigned                      last_pause;
    int unsigned                      roll;
    int unsigned                      l;
    int unsigned                      cnt;
    int unsigned                      last_pow;
    logic [spa_pkg::CmdW-1:0]         cmd;
    logic [spa_pkg::PowW-1:0]         pw;
    logic signed [spa_pkg::CoefW-1:0] cf;

    rst_ni             = 1'b0;
    start              = 1'b0;
    command_i          = spa_pkg::CmdLoadFirst;
    term_power_i       = '0;
    term_coefficient_i = '0;
    beats_sent         = 0;
    last_pause         = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    drive_gapped(spa_pkg::CmdAdd, 8'd0, 16'sh0000);          // both lists empty
    drive_gapped(spa_pkg::CmdUnused, 8'hff, 16'sh8000);      // unused command, no beat back
    drive_gapped(spa_pkg::CmdLoadFirst, 8'd255, 16'sh7fff);
    drive_gapped(spa_pkg::CmdAdd, 8'hff, 16'shffff);         // second list empty
    drive_gapped(spa_pkg::CmdLoadFirst, 8'd255, 16'sh0001);  // equal power, order reject
    drive_gapped(spa_pkg::CmdLoadSecond, 8'd255, 16'sh7fff);
    drive_gapped(spa_pkg::CmdAdd, 8'd0, 16'sh0000);          // largest positive sum
    drive_gapped(spa_pkg::CmdLoadSecond, 8'd200, 16'sh8000);
    drive_gapped(spa_pkg::CmdLoadSecond, 8'd201, 16'sh0005); // higher power, order reject
    drive_gapped(spa_pkg::CmdLoadFirst, 8'd200, 16'sh8000);
    drive_gapped(spa_pkg::CmdAdd, 8'd0, 16'sh0000);          // largest negative sum
    drive_gapped(spa_pkg::CmdLoadFirst, 8'd150, 16'sh0001);
    drive_gapped(spa_pkg::CmdLoadSecond, 8'd151, 16'shffff);
    drive_gapped(spa_pkg::CmdAdd, 8'd0, 16'sh0000);          // terms from one list only
    drive_gapped(spa_pkg::CmdLoadFirst, 8'd100, 16'sh0005);
    drive_gapped(spa_pkg::CmdLoadSecond, 8'd100, 16'shfffb);
    drive_gapped(spa_pkg::CmdAdd, 8'd0, 16'sh0000);          // zero sum kept
    wait_drained();

    // random part: well-formed loads dominate until both lists fill, adds in between
    while (beats_sent < RandBeats) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        cmd = spa_pkg::CmdW'($urandom_range(0, 3));
        pw  = spa_pkg::PowW'($urandom);
        cf  = spa_pkg::CoefW'($urandom);
        if (cmd != spa_pkg::CmdUnused) beats_sent++;
      end else if (roll < 28) begin
        cmd = spa_pkg::CmdAdd;
        pw  = spa_pkg::PowW'($urandom);
        cf  = spa_pkg::CoefW'($urandom);
        beats_sent++;
      end else begin
        l   = $urandom_range(0, 1);
        cmd = (l == 0) ? spa_pkg::CmdLoadFirst : spa_pkg::CmdLoadSecond;
        cf  = pick_coef();
        cnt = model.term_cnt[l];
        if (cnt >= spa_pkg::MaxTerms) begin
          pw = spa_pkg::PowW'($urandom);
        end else if (cnt != 0 && $urandom_range(0, 7) == 0) begin
          // broken order: power at or above the last one
          last_pow = model.term_pow[l][cnt-1];
          pw = spa_pkg::PowW'(last_pow + $urandom_range(0, 255 - last_pow));
        end else begin
          pw = next_power(l);
        end
        beats_sent++;
      end
      drive_gapped(cmd, pw, cf);
      if (beats_sent % 100 == 0 && beats_sent != last_pause) begin
        last_pause = beats_sent;
        wait_drained();
      end
    end

    start = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_datapath.sv
rtl/spa_ctrl.sv
rtl/sparse_polynomial_adder.sv
rtl/spa_checker.sv
bench/tb.sv
